// ===== hdl/ssfs_pkg.sv =====
`timescale 1ns / 1ps
package ssfs_pkg;

	localparam int DIFF_W    = 23;
	localparam int DOT_W     = 48;
	localparam int DOT_SHIFT = 16;
	localparam int NORM_BIT  = 30;
	localparam int TIME_W    = 25;
	localparam int CNT_W     = 6;
	localparam int IDX_W     = 3;

	localparam logic [TIME_W-1:0] TIME_RESET = 25'h1000000;
	localparam logic [CNT_W-1:0]  SQRT_LAST  = 6'd31;
	localparam logic [CNT_W-1:0]  DIV_LAST   = 6'd63;

	localparam logic [IDX_W-1:0] REG_BASE_X     = 3'd0;
	localparam logic [IDX_W-1:0] REG_BASE_Y     = 3'd1;
	localparam logic [IDX_W-1:0] REG_BASE_Z     = 3'd2;
	localparam logic [IDX_W-1:0] REG_VEL_X      = 3'd3;
	localparam logic [IDX_W-1:0] REG_VEL_Y      = 3'd4;
	localparam logic [IDX_W-1:0] REG_VEL_Z      = 3'd5;
	localparam logic [IDX_W-1:0] REG_TIME_LIMIT = 3'd6;

	typedef struct packed {
		logic               mode;
		logic               restart;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} feat_t;

	typedef struct packed {
		logic [TIME_W-1:0]  earliest_time;
		logic               found;
		logic               improved;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
	} rslt_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MUL, OP_WB, OP_VCOEF, OP_MAG, OP_NORM, OP_NEG,
		OP_SQRT_INIT, OP_SQRT_STEP, OP_ROOT_INIT, OP_DIV_STEP, OP_TAKE_T,
		OP_VHIT, OP_FQ_INIT, OP_FQ_ZERO, OP_FQ_TAKE, OP_COMMIT, OP_PUBLISH
	} dp_op_t;

	typedef enum logic [4:0] {
		S_VV, S_VW, S_WW, S_EE, S_EV, S_EW,
		S_EVEV, S_EEVV, S_EEVW, S_EVEW, S_EEOW, S_EWEW,
		S_BB, S_AC, S_EVT, S_EFQ
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t sel;
		logic [1:0] j;
		logic       root;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic need_norm;
		logic a_zero;
		logic d_neg;
		logic num0_pos;
		logic num1_pos;
		logic q_ok;
		logic fn_ok;
		logic ee_pos;
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DOT_MUL, ST_DOT_WB, ST_VCOEF, ST_CO_MUL, ST_CO_WB, ST_MAG,
		ST_NORM, ST_SIGN, ST_DS_MUL, ST_DS_WB, ST_DCHK, ST_SQRT, ST_ROOT,
		ST_RDIV, ST_QCHK, ST_VHIT, ST_FN_MUL, ST_FN_WB, ST_FN_CHK, ST_FDIV,
		ST_FQ_TAKE, ST_COMMIT, ST_CT_MUL, ST_CT_WB, ST_DONE
	} state_t;

endpackage

// ===== hdl/ssfs_ifs.sv =====
`timescale 1ns / 1ps
interface ssfs_feat_if;
	import ssfs_pkg::*;
	logic  valid;
	logic  ready;
	feat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ssfs_rslt_if;
	import ssfs_pkg::*;
	logic  valid;
	logic  ready;
	rslt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ssfs_dp.sv =====
`timescale 1ns / 1ps
module ssfs_dp #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int TIME_FRAC_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ssfs_pkg::IDX_W-1:0]   wr_index,
	input  logic [31:0]                  wr_data,
	input  ssfs_pkg::feat_t              feat,
	input  ssfs_pkg::cmd_t               cmd,
	output ssfs_pkg::stat_t              stat,
	output ssfs_pkg::rslt_t              res
);
	import ssfs_pkg::*;

	localparam int MW = 34;
	localparam logic signed [MW-1:0] ONE_E =
		{{(MW-1){1'b0}}, 1'b1} << (2*COORD_FRAC_BITS - DOT_SHIFT);
	localparam logic signed [63:0] C_ONE = 64'sd1 << (2*COORD_FRAC_BITS);

	function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [32:0] x);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = 33'sd4194303;
		lo = -33'sd4194304;
		if (x > hi) begin
			return hi[DIFF_W-1:0];
		end else if (x < lo) begin
			return lo[DIFF_W-1:0];
		end
		return x[DIFF_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	logic signed [31:0] base_q [3];
	logic signed [31:0] vel_q [3];
	logic [TIME_W-1:0]  limit_q;
	logic [TIME_W-1:0]  best_q;
	logic               hit_q;
	logic signed [31:0] cont_q [3];
	logic               imp_q;

	logic               mode_q;
	logic signed [31:0] p1_q [3];
	logic signed [DIFF_W-1:0] v_q [3];
	logic signed [DIFF_W-1:0] w_q [3];
	logic signed [DIFF_W-1:0] e_q [3];
	logic signed [DOT_W-1:0] vv_q, vw_q, ww_q, ee_q, ev_q, ew_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] a_q, b_q, c_q, dn_q, fn_q;
	logic [63:0]        m_q, r_q, bit_q, dq_q;
	logic [31:0]        rem_q, dsr_q, fq_q;
	logic [TIME_W-1:0]  t_q;
	rslt_t              res_q;

	logic signed [31:0] pf [3];
	logic signed [31:0] ps [3];
	logic signed [DOT_W-1:0] ee_sh, vv_sh, ev_sh, ew_sh, vw_sh, ww_sh;
	logic signed [31:0] eef, vvf, evf, ewf, vwf, wwf;
	logic signed [MW-1:0] one_ww;
	logic signed [MW-1:0] lhs, rhs;
	logic signed [2*MW-1:0] prod;
	logic signed [63:0] s_val, num0, num1, num_sel;
	logic [63:0]        r_bit;
	logic [32:0]        trial;
	logic               ge;

	assign pf[0] = feat.first_x;
	assign pf[1] = feat.first_y;
	assign pf[2] = feat.first_z;
	assign ps[0] = feat.second_x;
	assign ps[1] = feat.second_y;
	assign ps[2] = feat.second_z;

	assign ee_sh = ee_q >>> DOT_SHIFT;
	assign vv_sh = vv_q >>> DOT_SHIFT;
	assign ev_sh = ev_q >>> DOT_SHIFT;
	assign ew_sh = ew_q >>> DOT_SHIFT;
	assign vw_sh = vw_q >>> DOT_SHIFT;
	assign ww_sh = ww_q >>> DOT_SHIFT;
	assign eef = ee_sh[31:0];
	assign vvf = vv_sh[31:0];
	assign evf = ev_sh[31:0];
	assign ewf = ew_sh[31:0];
	assign vwf = vw_sh[31:0];
	assign wwf = ww_sh[31:0];
	assign one_ww = ONE_E - MW'(wwf);

	always_comb begin
		lhs = '0;
		rhs = '0;
		case (cmd.sel)
			S_VV: begin
				lhs = MW'(v_q[cmd.j]);
				rhs = MW'(v_q[cmd.j]);
			end
			S_VW: begin
				lhs = MW'(v_q[cmd.j]);
				rhs = MW'(w_q[cmd.j]);
			end
			S_WW: begin
				lhs = MW'(w_q[cmd.j]);
				rhs = MW'(w_q[cmd.j]);
			end
			S_EE: begin
				lhs = MW'(e_q[cmd.j]);
				rhs = MW'(e_q[cmd.j]);
			end
			S_EV: begin
				lhs = MW'(e_q[cmd.j]);
				rhs = MW'(v_q[cmd.j]);
			end
			S_EW: begin
				lhs = MW'(e_q[cmd.j]);
				rhs = MW'(w_q[cmd.j]);
			end
			S_EVEV: begin
				lhs = MW'(evf);
				rhs = MW'(evf);
			end
			S_EEVV: begin
				lhs = MW'(eef);
				rhs = MW'(vvf);
			end
			S_EEVW: begin
				lhs = MW'(eef);
				rhs = MW'(vwf);
			end
			S_EVEW: begin
				lhs = MW'(evf);
				rhs = MW'(ewf);
			end
			S_EEOW: begin
				lhs = MW'(eef);
				rhs = one_ww;
			end
			S_EWEW: begin
				lhs = MW'(ewf);
				rhs = MW'(ewf);
			end
			S_BB: begin
				lhs = b_q[MW-1:0];
				rhs = b_q[MW-1:0];
			end
			S_AC: begin
				lhs = a_q[MW-1:0];
				rhs = c_q[MW-1:0];
			end
			S_EVT: begin
				lhs = MW'(evf);
				rhs = MW'(signed'({1'b0, t_q}));
			end
			S_EFQ: begin
				lhs = MW'(e_q[cmd.j]);
				rhs = MW'(signed'({1'b0, fq_q}));
			end
			default: begin
				lhs = '0;
				rhs = '0;
			end
		endcase
	end

	assign prod    = lhs * rhs;
	assign s_val   = signed'(r_q);
	assign num0    = -b_q - s_val;
	assign num1    = -b_q + s_val;
	assign num_sel = cmd.root ? num1 : num0;
	assign r_bit   = r_q + bit_q;
	assign trial   = {rem_q, dq_q[63]};
	assign ge      = trial >= {1'b0, dsr_q};

	assign stat.mode      = mode_q;
	assign stat.need_norm = |m_q[63:NORM_BIT];
	assign stat.a_zero    = (a_q == '0);
	assign stat.d_neg     = dn_q[63];
	assign stat.num0_pos  = (num0 > 64'sd0);
	assign stat.num1_pos  = (num1 > 64'sd0);
	assign stat.q_ok      = (dq_q != '0) && (dq_q < 64'(best_q));
	assign stat.fn_ok     = !fn_q[63] && (fn_q <= (64'(eef) <<< TIME_FRAC_BITS));
	assign stat.ee_pos    = (eef > 32'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				base_q[i] <= '0;
				vel_q[i]  <= '0;
				cont_q[i] <= '0;
			end
			limit_q <= TIME_RESET;
			best_q  <= TIME_RESET;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_BASE_X:     base_q[0] <= wr_data;
					REG_BASE_Y:     base_q[1] <= wr_data;
					REG_BASE_Z:     base_q[2] <= wr_data;
					REG_VEL_X:      vel_q[0]  <= wr_data;
					REG_VEL_Y:      vel_q[1]  <= wr_data;
					REG_VEL_Z:      vel_q[2]  <= wr_data;
					REG_TIME_LIMIT: limit_q   <= wr_data[TIME_W-1:0];
					default: begin
					end
				endcase
			end
			case (cmd.op)
				OP_LOAD: begin
					if (feat.restart) begin
						best_q <= limit_q;
						hit_q  <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							cont_q[i] <= '0;
						end
					end
				end
				OP_VHIT: begin
					best_q <= t_q;
					hit_q  <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						cont_q[i] <= p1_q[i];
					end
				end
				OP_COMMIT: begin
					best_q <= t_q;
					hit_q  <= 1'b1;
				end
				OP_WB: begin
					if (cmd.sel == S_EFQ) begin
						cont_q[cmd.j] <= sat32(64'(p1_q[cmd.j]) + (prod_q >>> TIME_FRAC_BITS));
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q <= feat.mode;
				imp_q  <= 1'b0;
				vv_q <= '0;
				vw_q <= '0;
				ww_q <= '0;
				ee_q <= '0;
				ev_q <= '0;
				ew_q <= '0;
				for (int i = 0; i < 3; i++) begin
					p1_q[i] <= pf[i];
					v_q[i]  <= sat_diff(33'(vel_q[i]));
					e_q[i]  <= sat_diff(33'(ps[i]) - 33'(pf[i]));
					w_q[i]  <= feat.mode ? sat_diff(33'(pf[i]) - 33'(base_q[i]))
						: sat_diff(33'(base_q[i]) - 33'(pf[i]));
				end
			end
			OP_MUL: prod_q <= prod[63:0];
			OP_WB: begin
				case (cmd.sel)
					S_VV:   vv_q <= vv_q + prod_q[DOT_W-1:0];
					S_VW:   vw_q <= vw_q + prod_q[DOT_W-1:0];
					S_WW:   ww_q <= ww_q + prod_q[DOT_W-1:0];
					S_EE:   ee_q <= ee_q + prod_q[DOT_W-1:0];
					S_EV:   ev_q <= ev_q + prod_q[DOT_W-1:0];
					S_EW:   ew_q <= ew_q + prod_q[DOT_W-1:0];
					S_EVEV: a_q <= prod_q;
					S_EEVV: a_q <= a_q - prod_q;
					S_EEVW: b_q <= prod_q <<< 1;
					S_EVEW: b_q <= b_q - (prod_q <<< 1);
					S_EEOW: c_q <= prod_q;
					S_EWEW: c_q <= c_q + prod_q;
					S_BB:   dn_q <= prod_q;
					S_AC:   dn_q <= dn_q - (prod_q <<< 2);
					S_EVT:  fn_q <= prod_q - (64'(ewf) <<< TIME_FRAC_BITS);
					default: begin
					end
				endcase
			end
			OP_VCOEF: begin
				a_q <= 64'(vv_q);
				b_q <= 64'(vw_q) <<< 1;
				c_q <= 64'(ww_q) - C_ONE;
			end
			OP_MAG: m_q <= mag(a_q) | mag(b_q) | mag(c_q);
			OP_NORM: begin
				a_q <= a_q >>> 1;
				b_q <= b_q >>> 1;
				c_q <= c_q >>> 1;
				m_q <= m_q >> 1;
			end
			OP_NEG: begin
				if (a_q[63]) begin
					a_q <= -a_q;
					b_q <= -b_q;
					c_q <= -c_q;
				end
			end
			OP_SQRT_INIT: begin
				r_q   <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT_STEP: begin
				if (64'(dn_q) >= r_bit) begin
					dn_q <= dn_q - signed'(r_bit);
					r_q  <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_ROOT_INIT: begin
				dq_q  <= 64'(num_sel) << TIME_FRAC_BITS;
				rem_q <= '0;
				dsr_q <= {a_q[30:0], 1'b0};
			end
			OP_FQ_INIT: begin
				dq_q  <= 64'(fn_q);
				rem_q <= '0;
				dsr_q <= eef;
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
				dq_q  <= {dq_q[62:0], ge};
			end
			OP_TAKE_T:  t_q <= dq_q[TIME_W-1:0];
			OP_FQ_TAKE: fq_q <= dq_q[31:0];
			OP_FQ_ZERO: fq_q <= '0;
			OP_VHIT:    imp_q <= 1'b1;
			OP_COMMIT:  imp_q <= 1'b1;
			OP_PUBLISH: begin
				res_q.earliest_time <= best_q;
				res_q.found         <= hit_q;
				res_q.improved      <= imp_q;
				res_q.contact_x     <= cont_q[0];
				res_q.contact_y     <= cont_q[1];
				res_q.contact_z     <= cont_q[2];
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

// ===== hdl/ssfs_ctrl.sv =====
`timescale 1ns / 1ps
module ssfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ssfs_pkg::stat_t  stat,
	output ssfs_pkg::cmd_t   cmd
);
	import ssfs_pkg::*;

	function automatic mul_sel_t next_sel(input mul_sel_t s);
		case (s)
			S_VV:    return S_VW;
			S_VW:    return S_WW;
			S_WW:    return S_EE;
			S_EE:    return S_EV;
			S_EV:    return S_EW;
			S_EVEV:  return S_EEVV;
			S_EEVV:  return S_EEVW;
			S_EEVW:  return S_EVEW;
			S_EVEW:  return S_EEOW;
			S_EEOW:  return S_EWEW;
			S_BB:    return S_AC;
			default: return s;
		endcase
	endfunction

	state_t           state_q, state_d;
	mul_sel_t         sel_q, sel_d;
	logic [1:0]       j_q, j_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             root_q, root_d;
	logic             ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= S_VV;
			j_q     <= '0;
			cnt_q   <= '0;
			root_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			j_q     <= j_d;
			cnt_q   <= cnt_d;
			root_q  <= root_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		j_d      = j_q;
		cnt_d    = cnt_q;
		root_d   = root_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.j    = j_q;
		cmd.root = root_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					sel_d   = S_VV;
					j_d     = '0;
					state_d = ST_DOT_MUL;
				end
			end
			ST_DOT_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_DOT_WB;
			end
			ST_DOT_WB: begin
				cmd.op = OP_WB;
				if (j_q == 2'd2) begin
					j_d = '0;
					if (sel_q == S_EW) begin
						if (stat.mode) begin
							sel_d   = S_EVEV;
							state_d = ST_CO_MUL;
						end else begin
							state_d = ST_VCOEF;
						end
					end else begin
						sel_d   = next_sel(sel_q);
						state_d = ST_DOT_MUL;
					end
				end else begin
					j_d     = j_q + 2'd1;
					state_d = ST_DOT_MUL;
				end
			end
			ST_VCOEF: begin
				cmd.op  = OP_VCOEF;
				state_d = ST_MAG;
			end
			ST_CO_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_CO_WB;
			end
			ST_CO_WB: begin
				cmd.op = OP_WB;
				if (sel_q == S_EWEW) begin
					state_d = ST_MAG;
				end else begin
					sel_d   = next_sel(sel_q);
					state_d = ST_CO_MUL;
				end
			end
			ST_MAG: begin
				cmd.op  = OP_MAG;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				if (stat.need_norm) begin
					cmd.op = OP_NORM;
				end else begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (stat.a_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_NEG;
					sel_d   = S_BB;
					state_d = ST_DS_MUL;
				end
			end
			ST_DS_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_DS_WB;
			end
			ST_DS_WB: begin
				cmd.op = OP_WB;
				if (sel_q == S_AC) begin
					state_d = ST_DCHK;
				end else begin
					sel_d   = next_sel(sel_q);
					state_d = ST_DS_MUL;
				end
			end
			ST_DCHK: begin
				if (stat.d_neg) begin
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_SQRT_INIT;
					cnt_d   = '0;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SQRT_LAST) begin
					root_d  = 1'b0;
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_q ? stat.num1_pos : stat.num0_pos) begin
					cmd.op  = OP_ROOT_INIT;
					cnt_d   = '0;
					state_d = ST_RDIV;
				end else if (!root_q) begin
					root_d = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RDIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_QCHK;
				end
			end
			ST_QCHK: begin
				if (stat.q_ok) begin
					cmd.op = OP_TAKE_T;
					if (stat.mode) begin
						sel_d   = S_EVT;
						state_d = ST_FN_MUL;
					end else begin
						state_d = ST_VHIT;
					end
				end else if (!root_q) begin
					root_d  = 1'b1;
					state_d = ST_ROOT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_VHIT: begin
				cmd.op  = OP_VHIT;
				state_d = ST_DONE;
			end
			ST_FN_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_FN_WB;
			end
			ST_FN_WB: begin
				cmd.op  = OP_WB;
				state_d = ST_FN_CHK;
			end
			ST_FN_CHK: begin
				if (!stat.fn_ok) begin
					state_d = ST_DONE;
				end else if (stat.ee_pos) begin
					cmd.op  = OP_FQ_INIT;
					cnt_d   = '0;
					state_d = ST_FDIV;
				end else begin
					cmd.op  = OP_FQ_ZERO;
					state_d = ST_COMMIT;
				end
			end
			ST_FDIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_FQ_TAKE;
				end
			end
			ST_FQ_TAKE: begin
				cmd.op  = OP_FQ_TAKE;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.op  = OP_COMMIT;
				sel_d   = S_EFQ;
				j_d     = '0;
				state_d = ST_CT_MUL;
			end
			ST_CT_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_CT_WB;
			end
			ST_CT_WB: begin
				cmd.op = OP_WB;
				if (j_q == 2'd2) begin
					state_d = ST_DONE;
				end else begin
					j_d     = j_q + 2'd1;
					state_d = ST_CT_MUL;
				end
			end
			ST_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.op  = OP_PUBLISH;
					ov_d    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = ov_q;

endmodule

// ===== hdl/swept_sphere_feature_sweep.sv =====
`timescale 1ns / 1ps
// Swept unit sphere against a stream of triangle vertices and edges. Each word
// on feature gives one word on report. The work is done by one shared
// multiplier that forms the dot products and coefficients, each product in a
// multiply step and a write-back step, a normalizing shift of one bit per cycle,
// a 32-step square root, and a 64-step restoring divider used for each root
// tried and for the edge parameter. The next word is taken once the previous
// result sits in the report register.
module swept_sphere_feature_sweep #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int TIME_FRAC_BITS  = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ssfs_pkg::IDX_W-1:0] wr_index,
	input  logic [31:0]                wr_data,
	ssfs_feat_if.sink                  feature,
	ssfs_rslt_if.source                report
);
	import ssfs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ssfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feature.valid),
		.in_ready  (feature.ready),
		.out_valid (report.valid),
		.out_ready (report.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssfs_dp #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.TIME_FRAC_BITS  (TIME_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.feat     (feature.data),
		.cmd      (cmd),
		.stat     (stat),
		.res      (report.data)
	);

endmodule
